// ===== hw/rtl/fbs_pkg.sv =====
// fbs_pkg: shared types, constants and the band-stop coefficient table
// for the fir_bandstop_81tap filter. No dependencies.
package fbs_pkg;

    localparam int SAMPLE_W      = 16;
    localparam int COEF_W        = 16;
    localparam int PROD_W        = SAMPLE_W + COEF_W;
    localparam int PRODUCT_SHIFT = 15;
    localparam int NUM_COEFS     = 81;
    localparam int COEF_IDX_W    = $clog2(NUM_COEFS);
    localparam int IDX_W         = 8;   // tap index width, covers up to 256 taps

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [COEF_W-1:0]   coef_t;
    typedef logic signed [PROD_W-1:0]   prod_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } state_t;

    // sequencer -> MAC control
    typedef struct packed {
        logic clear;   // zero the accumulator for a new word
        logic valid;   // data and coefficient presented this cycle
    } mac_ctrl_t;

    // symmetric band-stop set, entry 0 weighs the oldest sample
    localparam coef_t COEFS [0:NUM_COEFS-1] = '{
        -16'sd1, -16'sd6, -16'sd11, -16'sd13, -16'sd9, -16'sd3, 16'sd0, -16'sd6,
        -16'sd24, -16'sd48, -16'sd65, -16'sd56, -16'sd14, 16'sd48, 16'sd102,
        16'sd114, 16'sd74, 16'sd12, -16'sd14, 16'sd52, 16'sd216, 16'sd416,
        16'sd537, 16'sd474, 16'sd209, -16'sd155, -16'sd432, -16'sd459, -16'sd217,
        16'sd119, 16'sd234, -16'sd154, -16'sd1093, -16'sd2297, -16'sd3205,
        -16'sd3223, -16'sd2027, 16'sd216, 16'sd2847, 16'sd4955,
        16'sd5760,
        16'sd4955, 16'sd2847, 16'sd216, -16'sd2027, -16'sd3223, -16'sd3205,
        -16'sd2297, -16'sd1093, -16'sd154, 16'sd234, 16'sd119,
        -16'sd217, -16'sd459, -16'sd432, -16'sd155, 16'sd209, 16'sd474, 16'sd537,
        16'sd416, 16'sd216, 16'sd52, -16'sd14, 16'sd12, 16'sd74, 16'sd114,
        16'sd102, 16'sd48, -16'sd14, -16'sd56, -16'sd65, -16'sd48, -16'sd24,
        -16'sd6, 16'sd0, -16'sd3, -16'sd9, -16'sd13, -16'sd11, -16'sd6, -16'sd1
    };

    // taps past the stored set weigh zero
    function automatic coef_t coef_at(input logic [IDX_W-1:0] idx);
        coef_t c;
        c = '0;
        if (idx < IDX_W'(NUM_COEFS)) begin
            c = COEFS[idx[COEF_IDX_W-1:0]];
        end
        return c;
    endfunction

endpackage

// ===== hw/rtl/fir_bandstop_81tap.sv =====
// fir_bandstop_81tap: top level of the 81-tap band-stop FIR filter.
// Depends on fbs_pkg, fbs_delay_mem and fbs_mac.
//
// Direct-form FIR band-stop filter on signed 16-bit samples. Each word taken
// on s_sample is shifted into an ORDER+1 entry delay line (all zero after
// reset) and one filtered word is returned on m_filtered: the sum over all
// taps of coefficient times delayed sample, each product floor-shifted right
// by 15, the sum wrapping to 16 bits. One multiplier serves every tap, one
// tap per cycle: the sequencer reads each of the ORDER+1 taps in turn, and
// each tap passes the memory read, multiply and accumulate registers before
// the sum goes to the output register. s_ready is high only while the
// sequencer is idle. The output register lets a finished word wait for
// m_ready while the next input word is already accepted.
module fir_bandstop_81tap #(
    parameter int ORDER = 80
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  fbs_pkg::sample_t s_sample,
    output logic             m_valid,
    input  logic             m_ready,
    output fbs_pkg::sample_t m_filtered
);

    localparam int TAPS  = ORDER + 1;
    localparam int TAP_W = $clog2(TAPS);

    fbs_pkg::state_t    state_reg, state_next;
    logic [TAP_W-1:0]   tap_reg, tap_next;
    fbs_pkg::coef_t     coef_reg;
    logic               m_valid_reg, m_valid_next;
    fbs_pkg::sample_t   m_filtered_reg;
    logic               load_out;
    logic               s_accept;
    logic               rd_en;
    fbs_pkg::sample_t   rd_data;
    logic               rd_vld;
    fbs_pkg::mac_ctrl_t mac_ctrl;
    fbs_pkg::sample_t   acc;
    logic               mac_busy;

    assign s_ready  = (state_reg == fbs_pkg::ST_IDLE);
    assign s_accept = s_valid && s_ready;

    // delay line: write on accept, then walk oldest to newest
    fbs_delay_mem #(
        .DEPTH (TAPS)
    ) u_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (s_accept),
        .wr_data (s_sample),
        .rd_en   (rd_en),
        .rd_data (rd_data),
        .rd_vld  (rd_vld)
    );

    // coefficient is registered from the read address, in step with the data
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            coef_reg <= fbs_pkg::coef_at(fbs_pkg::IDX_W'(tap_reg));
        end
    end

    assign mac_ctrl.clear = s_accept;
    assign mac_ctrl.valid = rd_vld;

    fbs_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (mac_ctrl),
        .data    (rd_data),
        .coef    (coef_reg),
        .acc     (acc),
        .busy    (mac_busy)
    );

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= fbs_pkg::ST_IDLE;
            tap_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            tap_reg     <= tap_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_filtered_reg <= acc;
        end
    end

    always_comb begin
        state_next   = state_reg;
        tap_next     = tap_reg;
        rd_en        = 1'b0;
        load_out     = 1'b0;
        m_valid_next = m_valid_reg && !m_ready;
        unique case (state_reg)
            fbs_pkg::ST_IDLE: begin
                tap_next = '0;
                if (s_accept) begin
                    state_next = fbs_pkg::ST_RUN;
                end
            end
            fbs_pkg::ST_RUN: begin
                rd_en = 1'b1;
                if (tap_reg == TAP_W'(ORDER)) begin
                    state_next = fbs_pkg::ST_DRAIN;
                end else begin
                    tap_next = tap_reg + 1'b1;
                end
            end
            fbs_pkg::ST_DRAIN: begin
                // wait for the last product to land, then for a free output
                if (!rd_vld && !mac_busy && (!m_valid_reg || m_ready)) begin
                    load_out     = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = fbs_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = fbs_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_valid    = m_valid_reg;
    assign m_filtered = m_filtered_reg;

    // an accepted word always starts a tap sweep
    a_accept_starts_run: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> (state_reg == fbs_pkg::ST_RUN) && (tap_reg == '0))
        else $error("accepted word did not start a tap sweep");

    // tap counter never passes the last tap
    a_tap_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        tap_reg <= TAP_W'(ORDER))
        else $error("tap counter out of range");

    // while idle the MAC pipeline holds nothing in flight
    a_idle_pipe_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == fbs_pkg::ST_IDLE) |-> (!rd_vld && !mac_busy))
        else $error("MAC pipeline busy while idle");

    // a result is loaded only into a free or draining output register
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |-> (!m_valid_reg || m_ready))
        else $error("output word overwritten before it was taken");

endmodule

// ===== hw/rtl/fbs_delay_mem.sv =====
// fbs_delay_mem: circular delay-line memory with per-entry valid bits.
// Depends on fbs_pkg.
module fbs_delay_mem #(
    parameter int DEPTH = 81
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             wr_en,
    input  fbs_pkg::sample_t wr_data,
    input  logic             rd_en,
    output fbs_pkg::sample_t rd_data,
    output logic             rd_vld
);

    localparam int PTR_W = $clog2(DEPTH);

    fbs_pkg::sample_t mem [0:DEPTH-1];

    logic [DEPTH-1:0] valid_reg;
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    fbs_pkg::sample_t rd_data_reg;
    logic             rd_hit_reg;
    logic             rd_vld_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_inc;

    assign wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_inc  = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_ptr_reg] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_ptr_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= '0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            rd_hit_reg <= 1'b0;
            rd_vld_reg <= 1'b0;
        end else begin
            rd_vld_reg <= rd_en;
            if (rd_en) begin
                rd_hit_reg <= valid_reg[rd_ptr_reg];
                rd_ptr_reg <= rd_ptr_inc;
            end
            if (wr_en) begin
                valid_reg[wr_ptr_reg] <= 1'b1;
                wr_ptr_reg            <= wr_ptr_next;
                // oldest entry sits right after the newest
                rd_ptr_reg            <= wr_ptr_next;
            end
        end
    end

    // never-written entries read as zero
    assign rd_data = rd_hit_reg ? rd_data_reg : '0;
    assign rd_vld  = rd_vld_reg;

endmodule

// ===== hw/rtl/fbs_mac.sv =====
// fbs_mac: shared multiply, floor-shift and 16-bit wrapping accumulate.
// Depends on fbs_pkg.
module fbs_mac (
    input  logic               aclk,
    input  logic               aresetn,
    input  fbs_pkg::mac_ctrl_t ctrl,
    input  fbs_pkg::sample_t   data,
    input  fbs_pkg::coef_t     coef,
    output fbs_pkg::sample_t   acc,
    output logic               busy
);

    fbs_pkg::prod_t   prod_reg;
    logic             prod_vld_reg;
    fbs_pkg::sample_t acc_reg;
    fbs_pkg::prod_t   shifted;

    // >>> on a signed value floors toward minus infinity
    assign shifted = prod_reg >>> fbs_pkg::PRODUCT_SHIFT;

    always_ff @(posedge aclk) begin
        if (ctrl.valid) begin
            prod_reg <= data * coef;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_vld_reg <= 1'b0;
            acc_reg      <= '0;
        end else begin
            prod_vld_reg <= ctrl.valid;
            if (ctrl.clear) begin
                acc_reg <= '0;
            end else if (prod_vld_reg) begin
                acc_reg <= acc_reg + shifted[fbs_pkg::SAMPLE_W-1:0];
            end
        end
    end

    assign acc  = acc_reg;
    assign busy = prod_vld_reg;

endmodule
